[hdl/byte_stack_with_rotate_macros.svh]
// ----------------------------------------------------------------------------
// Byte stack with rotate: assertion macros
// Clocked assertion wrappers used by the stack controller.
// ----------------------------------------------------------------------------
`ifndef BYTE_STACK_WITH_ROTATE_MACROS_SVH
`define BYTE_STACK_WITH_ROTATE_MACROS_SVH

// property checked on every rising edge outside reset
`define BSR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// expression that must never be true outside reset
`define BSR_NEVER(lbl, expr, msg) \
  `BSR_ASSERT(lbl, !(expr), msg)

`endif

[hdl/bsr_pkg.sv]
// ----------------------------------------------------------------------------
// Byte stack with rotate: package
// Operation codes, status codes, cell commands and controller states.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bsr_pkg;

  // span field covers every stack depth up to 64
  localparam int SPAN_W = 7;

  typedef enum logic [2:0] {
    OP_PUSH  = 3'd0,
    OP_POP   = 3'd1,
    OP_PEEK  = 3'd2,
    OP_DUP   = 3'd3,
    OP_ROTUP = 3'd4,
    OP_ROTDN = 3'd5,
    OP_PRINT = 3'd6
  } op_e;

  localparam logic [2:0] ST_DATA   = 3'd0;
  localparam logic [2:0] ST_OK     = 3'd1;
  localparam logic [2:0] ST_FULL   = 3'd2;
  localparam logic [2:0] ST_EMPTY  = 3'd3;
  localparam logic [2:0] ST_REJECT = 3'd4;

  typedef enum logic [2:0] {
    CK_HOLD,
    CK_PUSH,
    CK_DUP,
    CK_POP,
    CK_ROTUP,
    CK_ROTDN
  } cell_kind_e;

  typedef struct packed {
    cell_kind_e          kind;
    logic [SPAN_W-1:0]   span;
  } cell_cmd_t;

  typedef enum logic {
    S_IDLE,
    S_PRINT
  } state_e;

endpackage

[hdl/bsr_cell.sv]
// ----------------------------------------------------------------------------
// Byte stack with rotate: stack cell
// Holds the byte at one depth from the top and moves it along the chain.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bsr_cell #(
  parameter int IDX = 0
) (
  input  logic              clk,
  input  bsr_pkg::cell_cmd_t cmd,
  input  logic [7:0]        prev_q,
  input  logic [7:0]        next_q,
  input  logic [7:0]        top_q,
  output logic [7:0]        q
);

  localparam logic [bsr_pkg::SPAN_W-1:0] POS   = bsr_pkg::SPAN_W'(IDX);
  localparam logic [bsr_pkg::SPAN_W-1:0] POS_N = bsr_pkg::SPAN_W'(IDX + 1);

  logic [7:0] q_next;

  always_comb begin
    q_next = q;
    case (cmd.kind)
      bsr_pkg::CK_PUSH: q_next = prev_q;
      bsr_pkg::CK_DUP: begin
        if (IDX != 0) q_next = prev_q;
      end
      bsr_pkg::CK_POP: q_next = next_q;
      bsr_pkg::CK_ROTUP: begin
        if (POS_N < cmd.span) q_next = next_q;
        else if (POS_N == cmd.span) q_next = top_q;
      end
      bsr_pkg::CK_ROTDN: begin
        if (POS < cmd.span) q_next = prev_q;
      end
      default: q_next = q;
    endcase
  end

  always_ff @(posedge clk) begin
    q <= q_next;
  end

endmodule

[hdl/bsr_ctrl.sv]
// ----------------------------------------------------------------------------
// Byte stack with rotate: controller
// Input and output registers, fill count, capacity and cell chain commands.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "byte_stack_with_rotate_macros.svh"

module bsr_ctrl #(
  parameter int DEPTH = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [23:0]         s_tdata,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [15:0]         m_tdata,
  output logic                m_tlast,
  input  logic                cfg_we,
  input  logic [5:0]          cfg_wdata,
  input  logic [7:0]          cell_q [DEPTH],
  output bsr_pkg::cell_cmd_t  cmd,
  output logic [7:0]          inject
);

  localparam int FW = $clog2(DEPTH + 1);
  localparam int AW = $clog2(DEPTH);
  localparam int SW = bsr_pkg::SPAN_W;

  bsr_pkg::state_e state, state_next;
  logic [FW-1:0]   fill, fill_next;
  logic [FW-1:0]   rem, rem_next;
  logic [5:0]      capacity;

  logic            in_full;
  logic [2:0]      in_op;
  logic [7:0]      in_value;
  logic [5:0]      in_count;
  logic            in_take;

  logic            out_load;
  logic [7:0]      out_data, out_data_next;
  logic [2:0]      out_status, out_status_next;
  logic            out_last_next;

  logic            out_free;
  logic [SW-1:0]   fill_ext, cap_ext, n_ext, n_m1;
  logic            full, empty;

  assign s_tready = !in_full;
  assign out_free = !m_tvalid || m_tready;
  assign fill_ext = SW'(fill);
  assign cap_ext  = SW'(capacity);
  assign n_ext    = SW'(in_count);
  assign n_m1     = n_ext - SW'(1);
  assign full     = (fill_ext >= cap_ext) || (fill == FW'(DEPTH));
  assign empty    = (fill == '0);
  assign m_tdata  = {5'd0, out_status, out_data};

  always_comb begin
    state_next      = state;
    fill_next       = fill;
    rem_next        = rem;
    in_take         = 1'b0;
    out_load        = 1'b0;
    out_data_next   = 8'd0;
    out_status_next = bsr_pkg::ST_OK;
    out_last_next   = 1'b1;
    cmd.kind        = bsr_pkg::CK_HOLD;
    cmd.span        = '0;
    inject          = in_value;
    case (state)
      bsr_pkg::S_IDLE: begin
        if (in_full && out_free) begin
          in_take  = 1'b1;
          out_load = 1'b1;
          case (bsr_pkg::op_e'(in_op))
            bsr_pkg::OP_PUSH: begin
              if (full) begin
                out_status_next = bsr_pkg::ST_FULL;
              end else begin
                cmd.kind  = bsr_pkg::CK_PUSH;
                fill_next = fill + FW'(1);
              end
            end
            bsr_pkg::OP_POP, bsr_pkg::OP_PEEK: begin
              if (empty) begin
                out_status_next = bsr_pkg::ST_EMPTY;
              end else begin
                out_data_next   = cell_q[0];
                out_status_next = bsr_pkg::ST_DATA;
                if (bsr_pkg::op_e'(in_op) == bsr_pkg::OP_POP) begin
                  cmd.kind  = bsr_pkg::CK_POP;
                  fill_next = fill - FW'(1);
                end
              end
            end
            bsr_pkg::OP_DUP: begin
              if (empty) begin
                out_status_next = bsr_pkg::ST_EMPTY;
              end else if (full) begin
                out_status_next = bsr_pkg::ST_FULL;
              end else begin
                cmd.kind  = bsr_pkg::CK_DUP;
                fill_next = fill + FW'(1);
              end
            end
            bsr_pkg::OP_ROTUP, bsr_pkg::OP_ROTDN: begin
              if (n_ext > fill_ext) begin
                out_status_next = bsr_pkg::ST_REJECT;
              end else if (n_ext >= SW'(2)) begin
                cmd.span = n_ext;
                inject   = cell_q[n_m1[AW-1:0]];
                if (bsr_pkg::op_e'(in_op) == bsr_pkg::OP_ROTUP) cmd.kind = bsr_pkg::CK_ROTUP;
                else cmd.kind = bsr_pkg::CK_ROTDN;
              end
            end
            bsr_pkg::OP_PRINT: begin
              if (!empty) begin
                out_load   = 1'b0;
                rem_next   = fill;
                state_next = bsr_pkg::S_PRINT;
              end
            end
            default: out_status_next = bsr_pkg::ST_OK;
          endcase
        end
      end
      bsr_pkg::S_PRINT: begin
        if (out_free) begin
          // emit the top and rotate the whole stack up by one
          out_load        = 1'b1;
          out_data_next   = cell_q[0];
          out_status_next = bsr_pkg::ST_DATA;
          out_last_next   = (rem == FW'(1));
          cmd.kind        = bsr_pkg::CK_ROTUP;
          cmd.span        = fill_ext;
          rem_next        = rem - FW'(1);
          if (rem == FW'(1)) state_next = bsr_pkg::S_IDLE;
        end
      end
      default: state_next = bsr_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= bsr_pkg::S_IDLE;
      fill     <= '0;
      rem      <= '0;
      capacity <= 6'd32;
      in_full  <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      fill  <= fill_next;
      rem   <= rem_next;
      if (cfg_we) capacity <= cfg_wdata;
      if (s_tvalid && s_tready) in_full <= 1'b1;
      else if (in_take) in_full <= 1'b0;
      if (out_load) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_op    <= s_tdata[2:0];
      in_value <= s_tdata[10:3];
      in_count <= s_tdata[16:11];
    end
    if (out_load) begin
      out_data   <= out_data_next;
      out_status <= out_status_next;
      m_tlast    <= out_last_next;
    end
  end

  `BSR_NEVER(a_fill_bound, fill > FW'(DEPTH), "fill count beyond depth")
  `BSR_ASSERT(a_print_rem, (state == bsr_pkg::S_PRINT) |-> (rem != '0), "print with no words left")
  `BSR_ASSERT(a_mid_print, (m_tvalid && !m_tlast) |-> (state == bsr_pkg::S_PRINT), "non-final word outside print")
  `BSR_NEVER(a_in_overrun, (s_tvalid && s_tready) && in_full, "input register overrun")

endmodule

[hdl/byte_stack_with_rotate.sv]
// Byte LIFO stack built as a chain of byte cells, cell 0 holding the top. An input
// word is registered on acceptance and executed once the controller is idle and the
// output register is free; push, pop, peek, dup, rotate and unknown codes each give a
// single result. The input register holds one word, so no new word is accepted until
// the held one has been executed. A rotate of two or more moves the top count entries
// of the chain together. Print emits one word per cycle while the output register is
// free, one for each stored entry, taking the top and rotating the full stack up by
// one each time; the output register decides when each step may advance.
// ----------------------------------------------------------------------------
// Byte stack with rotate: top level
// Controller and the chain of stack cells.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module byte_stack_with_rotate #(
  parameter int DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // op[2:0], value[10:3], count[16:11], zero above
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // data[7:0], status[10:8], zero above
  output logic        m_tlast,
  input  logic        cfg_we,
  input  logic [5:0]  cfg_wdata  // capacity
);

  logic [7:0]         cell_q [DEPTH];
  bsr_pkg::cell_cmd_t cmd;
  logic [7:0]         inject;

  bsr_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .cell_q   (cell_q),
    .cmd      (cmd),
    .inject   (inject)
  );

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [7:0] prev_q;
    logic [7:0] next_q;
    if (i == 0) begin : g_first
      assign prev_q = inject;
    end else begin : g_mid
      assign prev_q = cell_q[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign next_q = cell_q[i];
    end else begin : g_inner
      assign next_q = cell_q[i+1];
    end
    bsr_cell #(
      .IDX(i)
    ) u_cell (
      .clk   (clk),
      .cmd   (cmd),
      .prev_q(prev_q),
      .next_q(next_q),
      .top_q (cell_q[0]),
      .q     (cell_q[i])
    );
  end

endmodule
